// File: src/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_WIDTH_DEF = 8;
  localparam int TAG_WIDTH_DEF = 16;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_POP = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

endpackage

// File: src/spq_cell.sv
// One storage cell of the sorted chain: compares, loads, or shifts its entry.
`timescale 1ns / 1ps
module spq_cell
  import spq_pkg::*;
#(
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF
) (
  input  logic                 clk,
  input  cell_ctrl_t           ctrl,
  input  logic                 occupied,
  input  logic [KEY_WIDTH-1:0] new_key,
  input  logic [TAG_WIDTH-1:0] new_tag,
  input  logic                 left_gt,
  input  logic [KEY_WIDTH-1:0] left_key,
  input  logic [TAG_WIDTH-1:0] left_tag,
  input  logic [KEY_WIDTH-1:0] right_key,
  input  logic [TAG_WIDTH-1:0] right_tag,
  output logic                 gt,
  output logic [KEY_WIDTH-1:0] key,
  output logic [TAG_WIDTH-1:0] tag
);

  // A free cell counts as greater, so a new entry lands after every held key not greater than it.
  assign gt = !occupied || (key > new_key);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      if (gt && !left_gt) begin
        key <= new_key;
        tag <= new_tag;
      end else if (gt) begin
        key <= left_key;
        tag <= left_tag;
      end
    end else if (ctrl.pop) begin
      key <= right_key;
      tag <= right_tag;
    end
  end

endmodule

// File: src/sorted_priority_queue.sv
// Top level of the sorted priority queue built as a chain of compare-and-shift cells.
//
//   channel  direction  handshake              payload
//   in       request    in_valid / in_ready    func, item_key, item_tag
//   out      result     out_valid / out_ready  out_key, out_tag, status, fill_count
//
// All cells compare against the new key at once and either load, shift from a neighbor,
// or hold, so a request can be accepted each cycle while no result waits on out_ready.
// The result is registered and appears in the cycle after acceptance.
// A waiting result stalls input only while out_ready is low.
// Reset clears the entry count and the result valid flag; cell contents and result
// fields are not cleared.
`timescale 1ns / 1ps
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 func,
  input  logic [KEY_WIDTH-1:0] item_key,
  input  logic [TAG_WIDTH-1:0] item_tag,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [KEY_WIDTH-1:0] out_key,
  output logic [TAG_WIDTH-1:0] out_tag,
  output logic [1:0]           status,
  output logic [CNT_W-1:0]     fill_count
);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  logic [CNT_W-1:0]     count;
  logic [CNT_W-1:0]     count_next;
  logic                 accept;
  logic                 is_full;
  logic                 is_empty;
  cell_ctrl_t           ctrl;
  logic [DEPTH-1:0]     cell_gt;
  logic [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic [TAG_WIDTH-1:0] cell_tag [DEPTH];

  assign in_ready = !out_valid || out_ready;
  assign accept = in_valid && in_ready;
  assign is_full = (count == FULL_COUNT);
  assign is_empty = (count == '0);

  always_comb begin
    ctrl.push = accept && (func == FUNC_PUSH) && !is_full;
    ctrl.pop = accept && (func == FUNC_POP) && !is_empty;
    count_next = count;
    if (ctrl.push) begin
      count_next = count + CNT_W'(1);
    end else if (ctrl.pop) begin
      count_next = count - CNT_W'(1);
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [CNT_W-1:0] IDX = CNT_W'(i);
    logic                 l_gt;
    logic [KEY_WIDTH-1:0] l_key;
    logic [TAG_WIDTH-1:0] l_tag;
    logic [KEY_WIDTH-1:0] r_key;
    logic [TAG_WIDTH-1:0] r_tag;

    if (i == 0) begin : g_first
      assign l_gt = 1'b0;
      assign l_key = '0;
      assign l_tag = '0;
    end else begin : g_mid
      assign l_gt = cell_gt[i-1];
      assign l_key = cell_key[i-1];
      assign l_tag = cell_tag[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_key = '0;
      assign r_tag = '0;
    end else begin : g_inner
      assign r_key = cell_key[i+1];
      assign r_tag = cell_tag[i+1];
    end

    spq_cell #(
      .KEY_WIDTH(KEY_WIDTH),
      .TAG_WIDTH(TAG_WIDTH)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .occupied (IDX < count),
      .new_key  (item_key),
      .new_tag  (item_tag),
      .left_gt  (l_gt),
      .left_key (l_key),
      .left_tag (l_tag),
      .right_key(r_key),
      .right_tag(r_tag),
      .gt       (cell_gt[i]),
      .key      (cell_key[i]),
      .tag      (cell_tag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      fill_count <= count_next;
      out_key <= '0;
      out_tag <= '0;
      status <= ST_OK;
      if (func == FUNC_PUSH) begin
        if (is_full) begin
          status <= ST_FULL;
        end
      end else if (is_empty) begin
        status <= ST_EMPTY;
      end else begin
        out_key <= cell_key[0];
        out_tag <= cell_tag[0];
      end
    end
  end

endmodule

// File: src/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
`timescale 1ns / 1ps
module spq_checker
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = TAG_WIDTH_DEF,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_ready,
  input logic                 func,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [KEY_WIDTH-1:0] out_key,
  input logic [TAG_WIDTH-1:0] out_tag,
  input logic [1:0]           status,
  input logic [CNT_W-1:0]     fill_count
);

  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> fill_count <= FULL_COUNT)
    else $error("fill count above depth");

  a_empty_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_EMPTY) |->
      (fill_count == '0 && out_key == '0 && out_tag == '0))
    else $error("empty pop result is not clean");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> fill_count == FULL_COUNT)
    else $error("dropped push without a full queue");

  a_pop_after_push_ok: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && func == FUNC_POP) |=> (out_valid && status != ST_FULL))
    else $error("pop reported as full");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(fill_count)))
    else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_checker #(
  .DEPTH    (DEPTH),
  .KEY_WIDTH(KEY_WIDTH),
  .TAG_WIDTH(TAG_WIDTH),
  .CNT_W    (CNT_W)
) u_spq_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .func      (func),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_key   (out_key),
  .out_tag   (out_tag),
  .status    (status),
  .fill_count(fill_count)
);

// File: tb/sv/tb_sorted_priority_queue.sv
// Self-checking testbench for the sorted priority queue: directed and random requests.
`timescale 1ns / 1ps
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int QDEPTH = DEPTH_DEF;
  localparam int STUCK_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 8;

  typedef struct packed {
    logic [7:0]  key;
    logic [15:0] tag;
    status_t     st;
    logic [4:0]  fill;
  } pq_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        func = FUNC_PUSH;
  logic [7:0]  item_key = '0;
  logic [15:0] item_tag = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_key;
  logic [15:0] out_tag;
  logic [1:0]  status;
  logic [4:0]  fill_count;

  logic [7:0]  held_keys [QDEPTH];
  logic [15:0] held_tags [QDEPTH];
  int          held_count = 0;

  pq_result_t  pending_results [$];
  int          mismatches = 0;
  int          stuck_cycles = 0;
  int          tx_idle_pct = 0;
  int          rx_idle_pct = 0;
  int          rx_stall_left = 0;

  sorted_priority_queue dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .func       (func),
    .item_key   (item_key),
    .item_tag   (item_tag),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_key    (out_key),
    .out_tag    (out_tag),
    .status     (status),
    .fill_count (fill_count)
  );

  always #1 clk = ~clk;

  function automatic pq_result_t apply_request(logic f, logic [7:0] k, logic [15:0] t);
    pq_result_t r;
    int pos;
    int i;
    r.key = '0;
    r.tag = '0;
    r.st = ST_OK;
    if (f == FUNC_PUSH) begin
      if (held_count >= QDEPTH) begin
        r.st = ST_FULL;
      end else begin
        pos = 0;
        while (pos < held_count && held_keys[pos] <= k) pos++;
        for (i = held_count; i > pos; i--) begin
          held_keys[i] = held_keys[i-1];
          held_tags[i] = held_tags[i-1];
        end
        held_keys[pos] = k;
        held_tags[pos] = t;
        held_count++;
      end
    end else begin
      if (held_count == 0) begin
        r.st = ST_EMPTY;
      end else begin
        r.key = held_keys[0];
        r.tag = held_tags[0];
        for (i = 1; i < held_count; i++) begin
          held_keys[i-1] = held_keys[i];
          held_tags[i-1] = held_tags[i];
        end
        held_count--;
      end
    end
    r.fill = held_count[4:0];
    return r;
  endfunction

  always @(posedge clk) begin : result_check
    pq_result_t exp;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request waiting: key %0d tag %0d status %0d fill %0d",
                 out_key, out_tag, status, fill_count);
          mismatches++;
        end else begin
          exp = pending_results.pop_front();
          if (out_key !== exp.key) begin
            $error("out_key expected %0d actual %0d", exp.key, out_key);
            mismatches++;
          end
          if (out_tag !== exp.tag) begin
            $error("out_tag expected %0d actual %0d", exp.tag, out_tag);
            mismatches++;
          end
          if (status !== exp.st) begin
            $error("status expected %0d actual %0d", exp.st, status);
            mismatches++;
          end
          if (fill_count !== exp.fill) begin
            $error("fill_count expected %0d actual %0d", exp.fill, fill_count);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        pending_results = {pending_results, apply_request(func, item_key, item_tag)};
      end
    end
  end

  always @(posedge clk) begin
    if (rx_stall_left != 0) begin
      out_ready <= 1'b0;
      rx_stall_left <= rx_stall_left - 1;
    end else if (rx_idle_pct != 0 && $urandom_range(99) < rx_idle_pct) begin
      out_ready <= 1'b0;
      rx_stall_left <= $urandom_range(5, 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_request(input logic f, input logic [7:0] k, input logic [15:0] t);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) idle_sender($urandom_range(6, 1));
    in_valid <= 1'b1;
    func <= f;
    item_key <= k;
    item_tag <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic send_random(input int push_pct, input bit narrow_keys);
    logic [7:0] k;
    if (narrow_keys) k = 8'($urandom_range(3) * 85);
    else k = 8'($urandom);
    send_request(($urandom_range(99) < push_pct) ? FUNC_PUSH : FUNC_POP, k, 16'($urandom));
  endtask

  task automatic test_basic_ops();
    send_request(FUNC_POP, 8'h00, 16'h0000);
    send_request(FUNC_PUSH, 8'hFF, 16'hFFFF);
    send_request(FUNC_PUSH, 8'h00, 16'h0000);
    send_request(FUNC_PUSH, 8'h80, 16'h1234);
    send_request(FUNC_PUSH, 8'h80, 16'h5678);
    send_request(FUNC_PUSH, 8'h80, 16'hA5A5);
    repeat (6) send_request(FUNC_POP, 8'hFF, 16'hFFFF);
  endtask

  task automatic test_full_queue();
    int i;
    for (i = 0; i < QDEPTH; i++) send_request(FUNC_PUSH, 8'((i * 7) % 5) * 8'd60, 16'(i));
    send_request(FUNC_PUSH, 8'h00, 16'hBEEF);
    send_request(FUNC_PUSH, 8'hFF, 16'hFFFF);
    for (i = 0; i <= QDEPTH; i++) send_request(FUNC_POP, 8'h00, 16'h0000);
  endtask

  task automatic test_pause_until_drained();
    tx_idle_pct = 25;
    rx_idle_pct = 30;
    repeat (20) send_random(60, 1'b0);
    wait_for_drain();
  endtask

  task automatic test_random_mix();
    int seg;
    int push_pct;
    bit narrow_keys;
    for (seg = 0; seg < 30; seg++) begin
      case ($urandom_range(2))
        0: push_pct = 80;
        1: push_pct = 50;
        default: push_pct = 20;
      endcase
      narrow_keys = ($urandom_range(2) == 0);
      if ($urandom_range(3) == 0) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else begin
        tx_idle_pct = $urandom_range(40, 10);
        rx_idle_pct = $urandom_range(40, 10);
      end
      repeat (50) send_random(push_pct, narrow_keys);
    end
  endtask

  task automatic test_back_to_back();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (40) send_random(85, 1'b1);
    repeat (60) send_random(40, 1'b0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_basic_ops();
    test_full_queue();
    test_pause_until_drained();
    test_random_mix();
    test_back_to_back();
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
